FILE: design/langevin_particle_step_histogram_macros.svh
// Assertion macros for the Langevin particle step histogram block.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef LANGEVIN_PARTICLE_STEP_HISTOGRAM_MACROS_SVH
`define LANGEVIN_PARTICLE_STEP_HISTOGRAM_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define LPSH_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LPSH_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/lpsh_pkg.sv
// Shared constants, codes and types for the Langevin particle step histogram.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package lpsh_pkg;

   // sizing
   localparam int MAX_PARTICLES = 1024;
   localparam int GRID_POINTS   = 512;
   localparam int PA_W          = $clog2(MAX_PARTICLES);
   localparam int BIN_W         = $clog2(GRID_POINTS);
   localparam int CLR_DEPTH     = (MAX_PARTICLES > GRID_POINTS) ? MAX_PARTICLES : GRID_POINTS;
   localparam int CLR_W         = $clog2(CLR_DEPTH);

   // field widths
   localparam int PIDX_W     = 10;
   localparam int BSEL_W     = 9;
   localparam int Q_W        = 32;
   localparam int CNT_W      = 16;
   localparam int DT_W       = 31;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SPRING_CONSTANT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP       = 1'b1;

   localparam logic [DT_W-1:0] TIME_STEP_RESET = 31'd65536;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MUL1,
      ST_RND1,
      ST_MUL2,
      ST_RND2,
      ST_ACCV,
      ST_NOISE,
      ST_MUL3,
      ST_RND3,
      ST_ACCX,
      ST_BIN,
      ST_HREAD,
      ST_HIST,
      ST_DRAIN
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_MUL1,
      OP_RND_F,
      OP_MUL_DT,
      OP_RND,
      OP_ACC_V,
      OP_NOISE,
      OP_ACC_X,
      OP_BIN,
      OP_HIST,
      OP_CLR_BIN
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
      logic mode;
   } dp_status_type;

endpackage

FILE: design/lpsh_req_if.sv
// Request channel interface: valid/ready plus one input item.
// Depends on lpsh_pkg for field widths.
`timescale 1ns / 1ps

interface lpsh_req_if;
   logic                              valid;
   logic                              ready;
   logic                              mode;
   logic [lpsh_pkg::PIDX_W-1:0]       particle_index;
   logic signed [lpsh_pkg::Q_W-1:0]   noise_sample;
   logic [lpsh_pkg::BSEL_W-1:0]       bin_select;

   modport source (output valid, mode, particle_index, noise_sample, bin_select,
                   input ready);
   modport sink   (input valid, mode, particle_index, noise_sample, bin_select,
                   output ready);
endinterface

FILE: design/lpsh_rsp_if.sv
// Response channel interface: valid/ready plus one result item.
// Depends on lpsh_pkg for field widths.
`timescale 1ns / 1ps

interface lpsh_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lpsh_pkg::BIN_W-1:0]        bin_index;
   logic signed [lpsh_pkg::Q_W-1:0]   new_position;
   logic [lpsh_pkg::CNT_W-1:0]        bin_count;

   modport source (output valid, bin_index, new_position, bin_count, input ready);
   modport sink   (input valid, bin_index, new_position, bin_count, output ready);
endinterface

FILE: design/lpsh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lpsh_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/lpsh_ctrl.sv
// Sequencer for the particle step: clear pass, item intake, multiply/round
// passes and histogram update or bin drain. Depends on lpsh_pkg.
`timescale 1ns / 1ps

module lpsh_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output lpsh_pkg::dp_cmd_type    cmd,
   input  lpsh_pkg::dp_status_type status
);

   lpsh_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpsh_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = lpsh_pkg::OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         lpsh_pkg::ST_CLEAR: begin
            cmd.op = lpsh_pkg::OP_CLEAR;
            if (status.clear_last) begin
               state_in = lpsh_pkg::ST_IDLE;
            end
         end
         lpsh_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = lpsh_pkg::OP_LOAD;
               state_in = lpsh_pkg::ST_READ;
            end
         end
         lpsh_pkg::ST_READ: begin
            state_in = status.mode ? lpsh_pkg::ST_DRAIN : lpsh_pkg::ST_MUL1;
         end
         lpsh_pkg::ST_MUL1: begin
            cmd.op   = lpsh_pkg::OP_MUL1;
            state_in = lpsh_pkg::ST_RND1;
         end
         lpsh_pkg::ST_RND1: begin
            cmd.op   = lpsh_pkg::OP_RND_F;
            state_in = lpsh_pkg::ST_MUL2;
         end
         lpsh_pkg::ST_MUL2: begin
            cmd.op   = lpsh_pkg::OP_MUL_DT;
            state_in = lpsh_pkg::ST_RND2;
         end
         lpsh_pkg::ST_RND2: begin
            cmd.op   = lpsh_pkg::OP_RND;
            state_in = lpsh_pkg::ST_ACCV;
         end
         lpsh_pkg::ST_ACCV: begin
            cmd.op   = lpsh_pkg::OP_ACC_V;
            state_in = lpsh_pkg::ST_NOISE;
         end
         lpsh_pkg::ST_NOISE: begin
            cmd.op   = lpsh_pkg::OP_NOISE;
            state_in = lpsh_pkg::ST_MUL3;
         end
         lpsh_pkg::ST_MUL3: begin
            cmd.op   = lpsh_pkg::OP_MUL_DT;
            state_in = lpsh_pkg::ST_RND3;
         end
         lpsh_pkg::ST_RND3: begin
            cmd.op   = lpsh_pkg::OP_RND;
            state_in = lpsh_pkg::ST_ACCX;
         end
         lpsh_pkg::ST_ACCX: begin
            cmd.op   = lpsh_pkg::OP_ACC_X;
            state_in = lpsh_pkg::ST_BIN;
         end
         lpsh_pkg::ST_BIN: begin
            cmd.op   = lpsh_pkg::OP_BIN;
            state_in = lpsh_pkg::ST_HREAD;
         end
         lpsh_pkg::ST_HREAD: begin
            state_in = lpsh_pkg::ST_HIST;
         end
         lpsh_pkg::ST_HIST: begin
            if (status.out_free) begin
               cmd.op   = lpsh_pkg::OP_HIST;
               state_in = lpsh_pkg::ST_IDLE;
            end
         end
         lpsh_pkg::ST_DRAIN: begin
            if (status.out_free) begin
               cmd.op   = lpsh_pkg::OP_CLR_BIN;
               state_in = lpsh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lpsh_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/lpsh_datapath.sv
// Datapath: config registers, particle and histogram RAMs, shared Q16.16
// multiplier with rounding, binning and the result register. Uses lpsh_pkg, lpsh_ram.
`timescale 1ns / 1ps

module lpsh_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  lpsh_pkg::dp_cmd_type                cmd,
   output lpsh_pkg::dp_status_type             status,
   input  logic                                csr_we,
   input  logic [lpsh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lpsh_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_mode,
   input  logic [lpsh_pkg::PIDX_W-1:0]         req_particle_index,
   input  logic signed [lpsh_pkg::Q_W-1:0]     req_noise_sample,
   input  logic [lpsh_pkg::BSEL_W-1:0]         req_bin_select,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lpsh_pkg::BIN_W-1:0]          rsp_bin_index,
   output logic signed [lpsh_pkg::Q_W-1:0]     rsp_new_position,
   output logic [lpsh_pkg::CNT_W-1:0]          rsp_bin_count
);

   localparam int Q_W   = lpsh_pkg::Q_W;
   localparam int BIN_W = lpsh_pkg::BIN_W;
   localparam int PA_W  = lpsh_pkg::PA_W;
   localparam int CNT_W = lpsh_pkg::CNT_W;
   localparam int CLR_W = lpsh_pkg::CLR_W;
   localparam int HALF  = lpsh_pkg::GRID_POINTS / 2;
   localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

   // |a|, valid for the most negative value as an unsigned result
   function automatic logic [Q_W-1:0] mag(input logic signed [Q_W-1:0] a);
      return a[Q_W-1] ? (32'd0 - a) : a;
   endfunction

   // Q16.16 product magnitude -> rounded half away from zero, saturated
   function automatic logic signed [Q_W-1:0] q_round(input logic [63:0] p,
                                                    input logic neg);
      logic [63:0] s;
      logic [47:0] m;
      logic signed [Q_W-1:0] r;
      s = p + 64'h8000;
      m = s[63:16];
      if (!neg) begin
         r = (m > 48'h7FFF_FFFF) ? Q_MAX : m[31:0];
      end else begin
         r = (m > 48'h8000_0000) ? Q_MIN : (32'd0 - m[31:0]);
      end
      return r;
   endfunction

   function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
                                                    input logic signed [Q_W-1:0] b);
      logic [Q_W:0] s;
      logic signed [Q_W-1:0] r;
      s = {a[Q_W-1], a} + {b[Q_W-1], b};
      if (s[Q_W] != s[Q_W-1]) begin
         r = s[Q_W] ? Q_MIN : Q_MAX;
      end else begin
         r = s[Q_W-1:0];
      end
      return r;
   endfunction

   // round x to an integer and map onto the grid, clamping to the edge bins
   function automatic logic [BIN_W-1:0] to_bin(input logic signed [Q_W-1:0] x);
      logic [Q_W:0]     xm;
      logic [Q_W:0]     s;
      logic [16:0]      nm;
      logic [BIN_W-1:0] b;
      xm = x[Q_W-1] ? (33'd0 - {x[Q_W-1], x}) : {1'b0, x};
      s  = xm + 33'h0_8000;
      nm = s[Q_W:16];
      if (nm < 17'(HALF)) begin
         b = x[Q_W-1] ? BIN_W'(17'(HALF) + nm) : BIN_W'(17'(HALF) - nm);
      end else begin
         b = x[Q_W-1] ? BIN_W'(lpsh_pkg::GRID_POINTS - 1) : '0;
      end
      return b;
   endfunction

   // control state
   logic signed [Q_W-1:0]         k_ff, k_in;
   logic [lpsh_pkg::DT_W-1:0]     dt_ff, dt_in;
   logic [CLR_W-1:0]              clr_ff, clr_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // payload
   logic                          mode_ff, mode_in;
   logic [PA_W-1:0]               pidx_ff, pidx_in;
   logic [BIN_W-1:0]              bin_ff, bin_in;
   logic signed [Q_W-1:0]         noise_ff, noise_in;
   logic signed [Q_W-1:0]         x_ff, x_in;
   logic signed [Q_W-1:0]         v_ff, v_in;
   logic signed [Q_W-1:0]         opnd_ff, opnd_in;
   logic signed [Q_W-1:0]         q_ff, q_in;
   logic [63:0]                   prod_ff, prod_in;
   logic                          neg_ff, neg_in;
   logic [BIN_W-1:0]              rsp_bin_ff, rsp_bin_in;
   logic signed [Q_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic [CNT_W-1:0]              rsp_cnt_ff, rsp_cnt_in;

   // memories
   logic                          pv_we;
   logic [PA_W-1:0]               pv_waddr;
   logic [2*Q_W-1:0]              pv_wdata, pv_rdata;
   logic                          h_we;
   logic [BIN_W-1:0]              h_waddr;
   logic [CNT_W-1:0]              h_wdata, h_rdata;

   logic signed [Q_W-1:0]         rd_x, rd_v;
   logic signed [Q_W-1:0]         mul_a, mul_b;
   logic [63:0]                   mul_p;
   logic signed [Q_W-1:0]         rnd_q;
   logic [CNT_W-1:0]              cnt_inc;

   lpsh_ram #(.DEPTH(lpsh_pkg::MAX_PARTICLES), .WIDTH(2*Q_W)) u_pv_ram (
      .clock (clock),
      .we    (pv_we),
      .waddr (pv_waddr),
      .wdata (pv_wdata),
      .raddr (pidx_ff),
      .rdata (pv_rdata)
   );

   lpsh_ram #(.DEPTH(lpsh_pkg::GRID_POINTS), .WIDTH(CNT_W)) u_hist_ram (
      .clock (clock),
      .we    (h_we),
      .waddr (h_waddr),
      .wdata (h_wdata),
      .raddr (bin_ff),
      .rdata (h_rdata)
   );

   assign rd_x = pv_rdata[2*Q_W-1:Q_W];
   assign rd_v = pv_rdata[Q_W-1:0];

   // shared multiplier: k*x on the first pass, operand*dt after that
   assign mul_a   = (cmd.op == lpsh_pkg::OP_MUL1) ? k_ff : opnd_ff;
   assign mul_b   = (cmd.op == lpsh_pkg::OP_MUL1) ? rd_x : {1'b0, dt_ff};
   assign mul_p   = 64'(mag(mul_a)) * 64'(mag(mul_b));
   assign rnd_q   = q_round(prod_ff, neg_ff);
   assign cnt_inc = (h_rdata == {CNT_W{1'b1}}) ? h_rdata : h_rdata + 16'd1;

   always_comb begin
      k_in         = k_ff;
      dt_in        = dt_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mode_in      = mode_ff;
      pidx_in      = pidx_ff;
      bin_in       = bin_ff;
      noise_in     = noise_ff;
      x_in         = x_ff;
      v_in         = v_ff;
      opnd_in      = opnd_ff;
      q_in         = q_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      rsp_bin_in   = rsp_bin_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      pv_we        = 1'b0;
      pv_waddr     = pidx_ff;
      pv_wdata     = {x_ff, v_ff};
      h_we         = 1'b0;
      h_waddr      = bin_ff;
      h_wdata      = cnt_inc;

      if (csr_we) begin
         case (csr_index)
            lpsh_pkg::CSR_SPRING_CONSTANT: k_in  = csr_wdata;
            lpsh_pkg::CSR_TIME_STEP:       dt_in = csr_wdata[lpsh_pkg::DT_W-1:0];
            default: ;
         endcase
      end

      case (cmd.op)
         lpsh_pkg::OP_LOAD: begin
            mode_in  = req_mode;
            pidx_in  = req_particle_index[PA_W-1:0];
            noise_in = req_noise_sample;
            bin_in   = req_bin_select;
         end
         lpsh_pkg::OP_CLEAR: begin
            clr_in   = clr_ff + 1'b1;
            pv_we    = ({1'b0, clr_ff} < (CLR_W+1)'(lpsh_pkg::MAX_PARTICLES));
            pv_waddr = clr_ff[PA_W-1:0];
            pv_wdata = '0;
            h_we     = ({1'b0, clr_ff} < (CLR_W+1)'(lpsh_pkg::GRID_POINTS));
            h_waddr  = clr_ff[BIN_W-1:0];
            h_wdata  = '0;
         end
         lpsh_pkg::OP_MUL1: begin
            x_in    = rd_x;
            v_in    = rd_v;
            prod_in = mul_p;
            neg_in  = k_ff[Q_W-1] ^ rd_x[Q_W-1];
         end
         lpsh_pkg::OP_RND_F: begin
            // f = -(k*x), with the one overflow case held at the top
            opnd_in = (rnd_q == Q_MIN) ? Q_MAX : (32'sd0 - rnd_q);
         end
         lpsh_pkg::OP_MUL_DT: begin
            prod_in = mul_p;
            neg_in  = opnd_ff[Q_W-1];
         end
         lpsh_pkg::OP_RND: begin
            q_in = rnd_q;
         end
         lpsh_pkg::OP_ACC_V: begin
            v_in = sat_add(v_ff, q_ff);
         end
         lpsh_pkg::OP_NOISE: begin
            opnd_in = sat_add(noise_ff, v_ff);
         end
         lpsh_pkg::OP_ACC_X: begin
            x_in = sat_add(x_ff, q_ff);
         end
         lpsh_pkg::OP_BIN: begin
            bin_in = to_bin(x_ff);
            pv_we  = 1'b1;
         end
         lpsh_pkg::OP_HIST: begin
            h_we         = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_bin_in   = bin_ff;
            rsp_pos_in   = x_ff;
            rsp_cnt_in   = cnt_inc;
         end
         lpsh_pkg::OP_CLR_BIN: begin
            h_we         = 1'b1;
            h_wdata      = '0;
            rsp_valid_in = 1'b1;
            rsp_bin_in   = bin_ff;
            rsp_pos_in   = '0;
            rsp_cnt_in   = h_rdata;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         dt_ff        <= lpsh_pkg::TIME_STEP_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         dt_ff        <= dt_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      pidx_ff    <= pidx_in;
      bin_ff     <= bin_in;
      noise_ff   <= noise_in;
      x_ff       <= x_in;
      v_ff       <= v_in;
      opnd_ff    <= opnd_in;
      q_ff       <= q_in;
      prod_ff    <= prod_in;
      neg_ff     <= neg_in;
      rsp_bin_ff <= rsp_bin_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign status.clear_last = (clr_ff == CLR_W'(lpsh_pkg::CLR_DEPTH - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.mode       = mode_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bin_index    = rsp_bin_ff;
   assign rsp_new_position = rsp_pos_ff;
   assign rsp_bin_count    = rsp_cnt_ff;

endmodule

FILE: design/langevin_particle_step_histogram.sv
// Top level of the Langevin particle step histogram: sequencer, datapath, ports.
// Uses lpsh_pkg, lpsh_req_if, lpsh_rsp_if, lpsh_ctrl, lpsh_datapath and the macros header.
`timescale 1ns / 1ps
`include "langevin_particle_step_histogram_macros.svh"

//  channel | dir | handshake       | beat contents
//  --------+-----+-----------------+------------------------------------------------
//  req_ch  | in  | valid / ready   | mode, particle_index, noise_sample, bin_select
//  rsp_ch  | out | valid / ready   | bin_index, new_position, bin_count
//  csr_*   | in  | csr_we only     | csr_index (0 spring_constant, 1 time_step), csr_wdata
//
// Mode 0 beat: the particle is read, then the one shared 32x32 multiplier runs
//   k*x, f*dt and (noise+v)*dt in turn, each multiply followed by a round step,
//   then the histogram read-modify-write; the next accept follows that write.
// Mode 1 beat: histogram read, then clear and report, before the next accept.
// Reset: a clearing pass zeroes both RAMs; req_ch.ready stays low
//   meanwhile, csr writes are taken.
// Stalls: the result register holds one beat; the next request is taken while it
//   waits, and that request's last step waits until the register is free.

module langevin_particle_step_histogram (
   input  logic                            clock,
   input  logic                            reset,
   lpsh_req_if.sink                        req_ch,
   lpsh_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [lpsh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lpsh_pkg::CSR_DATA_W-1:0] csr_wdata
);

   lpsh_pkg::dp_cmd_type    cmd;
   lpsh_pkg::dp_status_type status;
   logic                    req_ready;

   lpsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   lpsh_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_mode           (req_ch.mode),
      .req_particle_index (req_ch.particle_index),
      .req_noise_sample   (req_ch.noise_sample),
      .req_bin_select     (req_ch.bin_select),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_bin_index      (rsp_ch.bin_index),
      .rsp_new_position   (rsp_ch.new_position),
      .rsp_bin_count      (rsp_ch.bin_count)
   );

   assign req_ch.ready = req_ready;

   // one item in flight: intake closes straight after an accepted beat
   `LPSH_ASSERT_NEXT(a_one_in_flight, req_ch.valid && req_ch.ready, !req_ch.ready, "request taken while busy")
   // a finished result never overwrites one still waiting
   `LPSH_ASSERT_IMPL(a_rsp_no_overwrite, (cmd.op == lpsh_pkg::OP_HIST) || (cmd.op == lpsh_pkg::OP_CLR_BIN), status.out_free, "result register overwritten")
   // no intake during the clearing pass
   `LPSH_ASSERT_IMPL(a_no_req_in_clear, cmd.op == lpsh_pkg::OP_CLEAR, !req_ch.ready, "request open during clear")

endmodule
